>>> sv/lbsp_pkg.sv
package lbsp_pkg;

    localparam int STORE_BYTES_DEF    = 1024;
    localparam int MAX_FIELD_BITS_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int COUNT_W  = 6;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;
    localparam int SHIFT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_ATTACH = 3'd0,
        FN_SEEK   = 3'd1,
        FN_WRITE  = 3'd2,
        FN_READ   = 3'd3,
        FN_LOAD   = 3'd4,
        FN_FETCH  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIR  = 2'd1,
        ST_ROOM = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         off;
        logic [COUNT_W-1:0] rem;
        logic [7:0]         old_byte;
        logic [7:0]         rd_byte;
        logic [DATA_W-1:0]  val;
        logic [SHIFT_W-1:0] sh;
    } unit_in_t;

    typedef struct packed {
        logic [3:0]        take;
        logic [7:0]        byte_out;
        logic [DATA_W-1:0] acc_or;
        logic [DATA_W-1:0] val_shift;
    } unit_out_t;

endpackage

>>> sv/lsb_first_bit_stream_packer.sv
// Channel   Dir  Handshake                      tdata / tuser
// s_axis    in   s_axis_tvalid/s_axis_tready    bit_count,data_in,position,length / func
// m_axis    out  m_axis_tvalid/m_axis_tready    done_bits,read_value / status
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Attach, seek, load and refused items go straight to the finish state; fetch
// passes a fetch state. Write/read bits step over n touched bytes (32 bits at
// an offset: n = 5), one byte per cycle through the shared shift unit, after a prime
// state that loads the store's registered read port for a read or a mid-byte write.
// Reset (aresetn low, synchronous) sets both locks and clears length and cursor;
// the store is left as is. A stalled result holds in the output register while
// the next item is taken; the sequencer waits only if that register is still full.
module lsb_first_bit_stream_packer
    import lbsp_pkg::*;
#(
    parameter int STORE_BYTES    = STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // bit_count[5:0], data_in[37:6], position[48:38],
                                        // length[59:49]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // done_bits[5:0], read_value[37:6]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int LEN_W = ($clog2(STORE_BYTES + 1) > POS_W) ? $clog2(STORE_BYTES + 1) : POS_W;
    localparam int BP_W  = LEN_W + 3;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WPRIME = 7'b0000010,
        S_WSTEP  = 7'b0000100,
        S_RPRIME = 7'b0001000,
        S_RSTEP  = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [BP_W-1:0]    bitpos_reg, bitpos_next;
    logic               rlock_reg, rlock_next;
    logic               wlock_reg, wlock_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [SHIFT_W-1:0] sh_reg, sh_next;
    logic [COUNT_W-1:0] res_done_reg, res_done_next;
    logic [DATA_W-1:0]  res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_done_reg, m_done_next;
    logic [DATA_W-1:0]  m_value_reg, m_value_next;
    status_t            m_status_reg, m_status_next;

    logic [COUNT_W-1:0] in_count;
    logic [DATA_W-1:0]  in_data;
    logic [LEN_W-1:0]   in_pos;
    logic [LEN_W-1:0]   in_len;
    logic               accept;
    logic [LEN_W-1:0]   cur_byte;
    logic [2:0]         cur_off;
    logic [BP_W-1:0]    room;
    logic               too_long;
    logic               pos_ok;
    logic [COUNT_W-1:0] rem_after;

    logic               st_we;
    logic [AW-1:0]      st_waddr;
    logic [7:0]         st_wdata;
    logic [AW-1:0]      st_raddr;
    logic [7:0]         st_rdata;

    unit_in_t           u_in;
    unit_out_t          u_out;

    assign in_count = s_axis_tdata[5:0];
    assign in_data  = s_axis_tdata[37:6];
    assign in_pos   = LEN_W'(s_axis_tdata[48:38]);
    assign in_len   = LEN_W'(s_axis_tdata[59:49]);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cur_byte = bitpos_reg[BP_W-1:3];
    assign cur_off  = bitpos_reg[2:0];
    assign room     = {len_reg, 3'b000} - bitpos_reg;
    assign too_long = ({1'b0, in_count} > 7'(MAX_FIELD_BITS)) || (BP_W'(in_count) > room);
    assign pos_ok   = in_pos < LEN_W'(STORE_BYTES);

    assign u_in.off      = cur_off;
    assign u_in.rem      = rem_reg;
    assign u_in.old_byte = (cur_off != 3'd0) ? st_rdata : 8'h00;
    assign u_in.rd_byte  = st_rdata;
    assign u_in.val      = val_reg;
    assign u_in.sh       = sh_reg;

    assign rem_after = rem_reg - {2'b00, u_out.take};

    lbsp_shift_unit u_shift (
        .u_in  (u_in),
        .u_out (u_out)
    );

    lbsp_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        bitpos_next     = bitpos_reg;
        rlock_next      = rlock_reg;
        wlock_next      = wlock_reg;
        rem_next        = rem_reg;
        val_next        = val_reg;
        sh_next         = sh_reg;
        res_done_next   = res_done_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_done_next     = m_done_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        st_we           = 1'b0;
        st_waddr        = cur_byte[AW-1:0];
        st_wdata        = u_out.byte_out;
        st_raddr        = cur_byte[AW-1:0];

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                st_raddr = in_pos[AW-1:0];
                if (accept) begin
                    res_done_next   = '0;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    rem_next        = in_count;
                    val_next        = in_data;
                    sh_next         = '0;
                    state_next      = S_FIN;
                    case (func_t'(s_axis_tuser))
                        FN_ATTACH: begin
                            len_next    = (in_len > LEN_W'(STORE_BYTES))
                                        ? LEN_W'(STORE_BYTES) : in_len;
                            bitpos_next = '0;
                            rlock_next  = 1'b0;
                            wlock_next  = 1'b0;
                        end
                        FN_SEEK: begin
                            bitpos_next = {((in_pos < len_reg) ? in_pos : len_reg), 3'b000};
                        end
                        FN_WRITE: begin
                            if (wlock_reg) begin
                                res_status_next = ST_DIR;
                            end else begin
                                rlock_next = 1'b1;
                                if (too_long) begin
                                    res_status_next = ST_ROOM;
                                end else begin
                                    res_done_next = in_count;
                                    if (in_count != '0) begin
                                        state_next = (cur_off != 3'd0) ? S_WPRIME : S_WSTEP;
                                    end
                                end
                            end
                        end
                        FN_READ: begin
                            if (rlock_reg) begin
                                res_status_next = ST_DIR;
                            end else begin
                                wlock_next = 1'b1;
                                if (too_long) begin
                                    res_status_next = ST_ROOM;
                                end else begin
                                    res_done_next = in_count;
                                    if (in_count != '0) begin
                                        state_next = S_RPRIME;
                                    end
                                end
                            end
                        end
                        FN_LOAD: begin
                            if (pos_ok) begin
                                st_we         = 1'b1;
                                st_waddr      = in_pos[AW-1:0];
                                st_wdata      = in_data[7:0];
                                res_done_next = COUNT_W'(8);
                            end else begin
                                res_status_next = ST_ROOM;
                            end
                        end
                        FN_FETCH: begin
                            if (pos_ok) begin
                                res_done_next = COUNT_W'(8);
                                state_next    = S_FETCH;
                            end else begin
                                res_status_next = ST_ROOM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WPRIME: begin
                state_next = S_WSTEP;
            end
            S_WSTEP: begin
                st_we       = 1'b1;
                val_next    = u_out.val_shift;
                rem_next    = rem_after;
                bitpos_next = bitpos_reg + BP_W'(u_out.take);
                if (rem_after == '0) begin
                    state_next = S_FIN;
                end
            end
            S_RPRIME: begin
                state_next = S_RSTEP;
            end
            S_RSTEP: begin
                st_raddr       = AW'(cur_byte + LEN_W'(1));
                res_value_next = res_value_reg | u_out.acc_or;
                sh_next        = sh_reg + SHIFT_W'(u_out.take);
                rem_next       = rem_after;
                bitpos_next    = bitpos_reg + BP_W'(u_out.take);
                if (rem_after == '0) begin
                    state_next = S_FIN;
                end
            end
            S_FETCH: begin
                res_value_next = DATA_W'(st_rdata);
                state_next     = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_done_next   = res_done_reg;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            bitpos_reg  <= '0;
            rlock_reg   <= 1'b1;
            wlock_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            bitpos_reg  <= bitpos_next;
            rlock_reg   <= rlock_next;
            wlock_reg   <= wlock_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        val_reg        <= val_next;
        sh_reg         <= sh_next;
        res_done_reg   <= res_done_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_done_reg     <= m_done_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_value_reg, m_done_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

>>> sv/lbsp_store.sv
module lbsp_store
    import lbsp_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lbsp_shift_unit.sv
module lbsp_shift_unit
    import lbsp_pkg::*;
(
    input  unit_in_t  u_in,
    output unit_out_t u_out
);

    logic [3:0] avail;
    logic [3:0] take;
    logic [7:0] mask;
    logic [7:0] bits;
    logic [7:0] line;

    always_comb begin
        avail = 4'd8 - {1'b0, u_in.off};
        take  = (u_in.rem < {2'b00, avail}) ? u_in.rem[3:0] : avail;
        mask  = 8'((9'd1 << take) - 9'd1);
        bits  = u_in.val[7:0] & mask;
        line  = (u_in.rd_byte >> u_in.off) & mask;

        u_out.take      = take;
        u_out.byte_out  = u_in.old_byte | 8'({8'h00, bits} << u_in.off);
        u_out.val_shift = u_in.val >> take;
        u_out.acc_or    = (u_in.sh < SHIFT_W'(DATA_W))
                        ? ({{(DATA_W-8){1'b0}}, line} << u_in.sh[4:0])
                        : '0;
    end

endmodule
